### sv/pcxrle_pkg.sv
// Package for the PCX run-length line encoder.
// Holds run limits, the code marker and the burst record shared by the RTL modules.
`default_nettype none

package pcxrle_pkg;

  localparam int unsigned MAX_RUN   = 63;
  localparam int unsigned RUN_W     = 6;
  localparam int unsigned MAX_BURST = 5;
  localparam int unsigned BURST_W   = 3;

  localparam logic [7:0] CODE_MARK = 8'hC0;

  typedef struct packed {
    logic [MAX_BURST-1:0][7:0] bytes;
    logic [BURST_W-1:0]        count;
    logic                      line_end;
  } burst_t;

  typedef struct packed {
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
  } run_code_t;

endpackage

`default_nettype wire

### sv/pcxrle_if.sv
// Valid/ready channels of the PCX line encoder: scan-line bytes in, encoded bytes out.
// No dependencies.
`default_nettype none

interface pcxrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       end_of_line;

  modport source (output valid, output pixel_byte, output end_of_line, input ready);
  modport sink   (input valid, input pixel_byte, input end_of_line, output ready);
endinterface

interface pcxrle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       line_done;
  logic       last_of_burst;

  modport source (output valid, output out_byte, output line_done, output last_of_burst,
                  input ready);
  modport sink   (input valid, input out_byte, input line_done, input last_of_burst,
                  output ready);
endinterface

`default_nettype wire

### sv/pcxrle_run.sv
// Run tracker: holds the open run and line parity, builds the code burst for one beat.
// Depends on pcxrle_pkg.
`default_nettype none

module pcxrle_run (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   accept_i,
  input  wire  [7:0]            pixel_byte_i,
  input  wire                   end_of_line_i,
  output pcxrle_pkg::burst_t    burst_o
);
  import pcxrle_pkg::*;

  logic [7:0]       run_value_q, run_value_d;
  logic [RUN_W-1:0] run_length_q, run_length_d;
  logic             odd_count_q, odd_count_d;
  logic             in_line_q, in_line_d;

  run_code_t        brk_code, eol_code;
  logic             brk_emit;
  logic [7:0]       brk_value;
  logic [RUN_W-1:0] brk_length;
  logic [RUN_W-1:0] grown;

  function automatic run_code_t run_code(input logic [7:0] value,
                                         input logic [RUN_W-1:0] count);
    run_code_t c;
    c.b0  = CODE_MARK | {2'b00, count};
    c.b1  = value;
    c.len = 2'd2;
    if (count == '0) begin
      c.len = 2'd0;
    end else if (count == RUN_W'(1) && (value & CODE_MARK) != CODE_MARK) begin
      c.len = 2'd1;
      c.b0  = value;
    end
    return c;
  endfunction

  always_comb begin
    run_value_d  = run_value_q;
    run_length_d = run_length_q;
    odd_count_d  = odd_count_q;
    in_line_d    = in_line_q;
    brk_emit     = 1'b0;
    brk_value    = run_value_q;
    brk_length   = run_length_q;
    grown        = run_length_q + RUN_W'(1);

    if (!in_line_q) begin
      in_line_d    = 1'b1;
      odd_count_d  = 1'b1;
      run_value_d  = pixel_byte_i;
      run_length_d = RUN_W'(1);
    end else begin
      odd_count_d = ~odd_count_q;
      priority if (run_length_q == '0) begin
        run_value_d  = pixel_byte_i;
        run_length_d = RUN_W'(1);
      end else if (pixel_byte_i == run_value_q) begin
        run_length_d = grown;
        if (grown >= RUN_W'(MAX_RUN)) begin
          brk_emit     = 1'b1;
          brk_length   = grown;
          run_length_d = '0;
        end
      end else begin
        brk_emit     = 1'b1;
        run_value_d  = pixel_byte_i;
        run_length_d = RUN_W'(1);
      end
    end

    brk_code = run_code(brk_value, brk_emit ? brk_length : '0);
    eol_code = run_code(run_value_d, end_of_line_i ? run_length_d : '0);

    if (end_of_line_i) begin
      run_length_d = '0;
      odd_count_d  = 1'b0;
      in_line_d    = 1'b0;
    end
  end

  always_comb begin
    logic [BURST_W-1:0] pos;
    pos             = '0;
    burst_o.bytes   = '0;
    if (brk_code.len != 2'd0) begin
      burst_o.bytes[pos] = brk_code.b0;
      pos = pos + BURST_W'(1);
    end
    if (brk_code.len == 2'd2) begin
      burst_o.bytes[pos] = brk_code.b1;
      pos = pos + BURST_W'(1);
    end
    if (eol_code.len != 2'd0) begin
      burst_o.bytes[pos] = eol_code.b0;
      pos = pos + BURST_W'(1);
    end
    if (eol_code.len == 2'd2) begin
      burst_o.bytes[pos] = eol_code.b1;
      pos = pos + BURST_W'(1);
    end
    if (end_of_line_i && in_line_d == 1'b0 && (in_line_q ? ~odd_count_q : 1'b1)) begin
      burst_o.bytes[pos] = 8'h00;
      pos = pos + BURST_W'(1);
    end
    burst_o.count    = pos;
    burst_o.line_end = end_of_line_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_value_q  <= '0;
      run_length_q <= '0;
      odd_count_q  <= 1'b0;
      in_line_q    <= 1'b0;
    end else if (accept_i) begin
      run_value_q  <= run_value_d;
      run_length_q <= run_length_d;
      odd_count_q  <= odd_count_d;
      in_line_q    <= in_line_d;
    end
  end

endmodule

`default_nettype wire

### sv/pcxrle_burst.sv
// Burst buffer: holds the encoded bytes of one beat and sends them one per cycle while the output is ready.
// Depends on pcxrle_pkg and pcxrle_out_if.
`default_nettype none

module pcxrle_burst (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 load_i,
  input  pcxrle_pkg::burst_t  burst_i,
  output logic                free_o,
  pcxrle_out_if.source        out_o
);
  import pcxrle_pkg::*;

  logic [MAX_BURST-1:0][7:0] bytes_q;
  logic [BURST_W-1:0]        count_q;
  logic [BURST_W-1:0]        idx_q;
  logic                      line_end_q;
  logic                      last;
  logic                      fire;

  assign last   = (idx_q == count_q - BURST_W'(1));
  assign fire   = out_o.valid && out_o.ready;
  assign free_o = (count_q == '0) || (fire && last);

  assign out_o.valid         = (count_q != '0);
  assign out_o.out_byte      = bytes_q[idx_q];
  assign out_o.last_of_burst = last;
  assign out_o.line_done     = last && line_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else if (load_i) begin
      count_q <= burst_i.count;
      idx_q   <= '0;
    end else if (fire) begin
      if (last) begin
        count_q <= '0;
        idx_q   <= '0;
      end else begin
        idx_q <= idx_q + BURST_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q    <= burst_i.bytes;
      line_end_q <= burst_i.line_end;
    end
  end

endmodule

`default_nettype wire

### sv/pcx_rle_line_encoder_core.sv
// Top level of the PCX run-length line encoder.
// Depends on pcxrle_pkg, pcxrle_if, pcxrle_run and pcxrle_burst.
//
//   channel  dir  payload                                  beat
//   in_i     in   pixel_byte, end_of_line                  one scan-line byte
//   out_o    out  out_byte, line_done, last_of_burst       one encoded byte
//
// A byte enters when the buffer is free; its codes (zero to five) leave one per
// cycle from the burst buffer while the output is ready; the single output port
// sets how long a beat holds the input. A beat with no codes does not hold it.
// Reset clears the run, parity and line state and empties the buffer.
// A stalled output holds the buffer; input is taken as its last code leaves.
`default_nettype none

module pcx_rle_line_encoder_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  pcxrle_in_if.sink    in_i,
  pcxrle_out_if.source out_o
);
  import pcxrle_pkg::*;

  burst_t burst;
  logic   free;
  logic   accept;

  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  pcxrle_run u_run (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .pixel_byte_i  (in_i.pixel_byte),
    .end_of_line_i (in_i.end_of_line),
    .burst_o       (burst)
  );

  pcxrle_burst u_burst (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .burst_i (burst),
    .free_o  (free),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

### bench/pcx_rle_code_check.sv
// Watches the scan-line byte and encoded byte channels of the PCX line encoder.
// Predicts each burst of run-length codes and compares every output beat in order.
// Depends on pcxrle_pkg and pcxrle_if.
`timescale 1ns / 1ps

module pcx_rle_code_check (
  input  wire   clk_i,
  input  wire   rst_ni,
  pcxrle_in_if  in_ch,
  pcxrle_out_if out_ch,
  output int    pending_o,
  output int    errors_o
);
  import pcxrle_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       line_done;
    logic       burst_end;
  } enc_byte_t;

  enc_byte_t expected_codes[$];
  enc_byte_t burst_buf[MAX_BURST];
  int        burst_n;

  logic [7:0]       run_val;
  logic [RUN_W-1:0] run_len;
  logic             odd_bytes;
  logic             line_open;

  initial begin
    errors_o = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    errors_o++;
  endtask

  task automatic add_code(input logic [7:0] b);
    burst_buf[burst_n] = '{code: b, line_done: 1'b0, burst_end: 1'b0};
    burst_n++;
  endtask

  task automatic add_run(input logic [7:0] v, input logic [RUN_W-1:0] len);
    if (len == '0) begin
      return;
    end
    if (len == RUN_W'(1) && (v & CODE_MARK) != CODE_MARK) begin
      add_code(v);
    end else begin
      add_code(CODE_MARK | {2'b00, len});
      add_code(v);
    end
  endtask

  task automatic predict_codes(input logic [7:0] b, input logic eol);
    burst_n = 0;
    if (!line_open) begin
      line_open = 1'b1;
      odd_bytes = 1'b1;
      run_val   = b;
      run_len   = RUN_W'(1);
    end else begin
      odd_bytes = ~odd_bytes;
      if (run_len == '0) begin
        run_val = b;
        run_len = RUN_W'(1);
      end else if (b == run_val) begin
        run_len = run_len + RUN_W'(1);
        if (run_len >= RUN_W'(MAX_RUN)) begin
          add_run(run_val, run_len);
          run_len = '0;
        end
      end else begin
        add_run(run_val, run_len);
        run_val = b;
        run_len = RUN_W'(1);
      end
    end
    if (eol) begin
      add_run(run_val, run_len);
      if (odd_bytes) begin
        add_code(8'h00);
      end
      run_len   = '0;
      odd_bytes = 1'b0;
      line_open = 1'b0;
      if (burst_n > 0) begin
        burst_buf[burst_n-1].line_done = 1'b1;
      end
    end
    if (burst_n > 0) begin
      burst_buf[burst_n-1].burst_end = 1'b1;
    end
    for (int i = 0; i < burst_n; i++) begin
      expected_codes.push_back(burst_buf[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    enc_byte_t want;
    if (!rst_ni) begin
      run_val   = '0;
      run_len   = '0;
      odd_bytes = 1'b0;
      line_open = 1'b0;
      expected_codes.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_codes(in_ch.pixel_byte, in_ch.end_of_line);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_codes.size() == 0) begin
          report_mismatch("unexpected beat, out_byte", out_ch.out_byte, 0);
        end else begin
          want = expected_codes.pop_front();
          if (out_ch.out_byte !== want.code) begin
            report_mismatch("out_byte", out_ch.out_byte, want.code);
          end
          if (out_ch.line_done !== want.line_done) begin
            report_mismatch("line_done", out_ch.line_done, want.line_done);
          end
          if (out_ch.last_of_burst !== want.burst_end) begin
            report_mismatch("last_of_burst", out_ch.last_of_burst, want.burst_end);
          end
        end
      end
    end
    pending_o <= expected_codes.size();
  end

endmodule

### bench/pcx_rle_line_encoder_core_tb.sv
// Testbench top for pcx_rle_line_encoder_core: drives scan lines and the output stall.
// Directed lines first, then random lines of runs or of random bytes; checking lives in pcx_rle_code_check.
// Depends on pcxrle_pkg, pcxrle_if, the encoder RTL and pcx_rle_code_check.
`timescale 1ns / 1ps

module pcx_rle_line_encoder_core_tb;

  localparam int IDLE_PCT    = 14;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int ITEM_TARGET = 150;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic steady = 1'b0;
  logic hold_req = 1'b0;
  int   pending;
  int   errors;
  int   bytes_sent = 0;
  int   idle_cycles = 0;

  pcxrle_in_if  in_ch ();
  pcxrle_out_if out_ch ();

  pcx_rle_line_encoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  pcx_rle_code_check u_code_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .pending_o (pending),
    .errors_o  (errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ch.ready = steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input logic eol);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_ch.valid       = 1'b1;
    in_ch.pixel_byte  = b;
    in_ch.end_of_line = eol;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line(input logic [7:0] line_q[$]);
    foreach (line_q[i]) begin
      send_beat(line_q[i], i == line_q.size() - 1);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic build_line(output logic [7:0] line_q[$], input bit force_long);
    int         runs;
    int         len;
    int         pick;
    logic [7:0] v;
    line_q = {};
    runs = $urandom_range(1, 8);
    for (int r = 0; r < runs; r++) begin
      v    = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (force_long && r == 0) begin
        len = $urandom_range(63, 70);
      end else if (pick < 10) begin
        len = 1;
      end else if (pick < 80) begin
        len = $urandom_range(1, 3);
      end else if (pick < 96) begin
        len = $urandom_range(4, 10);
      end else begin
        len = $urandom_range(60, 66);
      end
      repeat (len) line_q.push_back(v);
    end
  endtask

  initial begin
    logic [7:0] line_q[$];
    int         line_no;
    in_ch.valid       = 1'b0;
    in_ch.pixel_byte  = '0;
    in_ch.end_of_line = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_line('{8'h00});
    hold_req = 1'b1;
    send_line('{8'hBF, 8'hC0, 8'hFF, 8'hFF, 8'h3F});
    send_line('{8'h01, 8'h01, 8'hE0});
    send_line('{8'hC0});
    send_line('{8'hFF, 8'hFF});
    send_line('{8'h80, 8'h7F, 8'hAA, 8'h55});
    send_line('{8'h40, 8'h40, 8'h40});
    wait_drained();

    line_no = 0;
    while (bytes_sent < ITEM_TARGET) begin
      steady = (line_no == 0);
      if (line_no != 0 && $urandom_range(99) < 15) begin
        line_q = {};
        repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(255)));
      end else begin
        build_line(line_q, line_no == 0);
      end
      send_line(line_q);
      line_no++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
sv/pcxrle_pkg.sv
sv/pcxrle_if.sv
sv/pcxrle_run.sv
sv/pcxrle_burst.sv
sv/pcx_rle_line_encoder_core.sv
bench/pcx_rle_code_check.sv
bench/pcx_rle_line_encoder_core_tb.sv
